FILE: rtl/mi_pkg.sv
// Shared types, microcode encodings and step addresses for the modular inverse block.
package mi_pkg;

  typedef struct packed {
    logic signed [63:0] value;
    logic        [62:0] modulus;
  } in_t;

  typedef struct packed {
    logic [62:0] inverse;
    logic        no_inverse;
  } out_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RED_SET,
    OP_DIV_STEP,
    OP_RED_FIX,
    OP_EU_SET,
    OP_EU_UPD,
    OP_FOLD,
    OP_EMIT_INV,
    OP_EMIT_FAIL,
    OP_EMIT_ZERO
  } op_t;

  // Jump conditions; a true condition loads the target, otherwise advance
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_M_ZERO,
    C_M_ONE,
    C_DIV_MORE,
    C_R1_ZERO,
    C_GCD_NOT1
  } cond_t;

  localparam int PC_W = 5;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic no_input;
    logic m_zero;
    logic m_one;
    logic div_more;
    logic r1_zero;
    logic gcd_not1;
    logic out_busy;
  } status_t;

  // Program step addresses
  localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] PC_CHK_ZERO = 5'd1;
  localparam logic [PC_W-1:0] PC_CHK_ONE  = 5'd2;
  localparam logic [PC_W-1:0] PC_RED_SET  = 5'd3;
  localparam logic [PC_W-1:0] PC_RED_DIV  = 5'd4;
  localparam logic [PC_W-1:0] PC_RED_FIX  = 5'd5;
  localparam logic [PC_W-1:0] PC_EU_TEST  = 5'd6;
  localparam logic [PC_W-1:0] PC_EU_SET   = 5'd7;
  localparam logic [PC_W-1:0] PC_EU_DIV   = 5'd8;
  localparam logic [PC_W-1:0] PC_EU_UPD   = 5'd9;
  localparam logic [PC_W-1:0] PC_FOLD     = 5'd10;
  localparam logic [PC_W-1:0] PC_EMIT_INV = 5'd11;
  localparam logic [PC_W-1:0] PC_END_INV  = 5'd12;
  localparam logic [PC_W-1:0] PC_EMIT_NO  = 5'd13;
  localparam logic [PC_W-1:0] PC_END_NO   = 5'd14;
  localparam logic [PC_W-1:0] PC_EMIT_ONE = 5'd15;
  localparam logic [PC_W-1:0] PC_END_ONE  = 5'd16;

endpackage

FILE: rtl/modular_inverse.sv
// Top level of the modular inverse block: sequencer plus datapath.
//
// Usage: present a signed value and a positive modulus on in_data with
// in_valid; the item is taken when in_valid and in_ready are both high.
// The low WIDTH bits of value are used, read as signed, and the low WIDTH-1
// bits of modulus. One result beat per item leaves on out_data under
// out_valid/out_ready: the inverse in 0..modulus-1, or zero with no_inverse
// set when value and modulus share a factor (a reduced value of zero too).
// A modulus of one gives zero with no_inverse clear.
//
// Timing: one item at a time. The reduction and every quotient step of
// Euclid each run one division on the shared shift-subtract divider, which
// delivers one quotient bit per cycle. After the result is emitted the
// sequencer returns to idle through its end step. A 63-bit modulus allows
// at most 90 quotient steps (consecutive Fibonacci operands).
// in_ready is high only while the sequencer sits at its idle step.
//
// Reset clears the step counter and the result valid flag. A stalled
// receiver holds the result; the sequencer waits at its emit step until
// the register frees, and a waiting result does not block a new input beat.
module modular_inverse #(
  parameter int WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mi_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mi_pkg::out_t  out_data
);
  import mi_pkg::*;

  op_t     op;
  status_t status;
  logic    idle;

  mi_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op),
    .idle   (idle)
  );

  mi_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

  // accept only at the idle step
  assign in_ready = idle;

  // A failed inverse always reads as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.no_inverse && out_data.inverse != '0))
    else $error("no_inverse result carries a nonzero inverse");

  // An accepted beat moves the sequencer off the idle step
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer stayed idle after an input beat");

  // A fresh result only comes from a busy sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the sequencer was idle");

endmodule

FILE: rtl/mi_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module mi_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  mi_pkg::status_t status,
  output mi_pkg::op_t     op,
  output logic            idle
);
  import mi_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ctrl_t           ctrl;
  logic            take;

  // Control store
  always_comb begin
    unique case (pc_r)
      PC_IDLE:     ctrl = '{OP_LOAD,      C_NO_INPUT, PC_IDLE};
      PC_CHK_ZERO: ctrl = '{OP_NOP,       C_M_ZERO,   PC_EMIT_NO};
      PC_CHK_ONE:  ctrl = '{OP_NOP,       C_M_ONE,    PC_EMIT_ONE};
      PC_RED_SET:  ctrl = '{OP_RED_SET,   C_NONE,     PC_IDLE};
      PC_RED_DIV:  ctrl = '{OP_DIV_STEP,  C_DIV_MORE, PC_RED_DIV};
      PC_RED_FIX:  ctrl = '{OP_RED_FIX,   C_NONE,     PC_IDLE};
      PC_EU_TEST:  ctrl = '{OP_NOP,       C_R1_ZERO,  PC_FOLD};
      PC_EU_SET:   ctrl = '{OP_EU_SET,    C_NONE,     PC_IDLE};
      PC_EU_DIV:   ctrl = '{OP_DIV_STEP,  C_DIV_MORE, PC_EU_DIV};
      PC_EU_UPD:   ctrl = '{OP_EU_UPD,    C_ALWAYS,   PC_EU_TEST};
      PC_FOLD:     ctrl = '{OP_FOLD,      C_GCD_NOT1, PC_EMIT_NO};
      PC_EMIT_INV: ctrl = '{OP_EMIT_INV,  C_NONE,     PC_IDLE};
      PC_END_INV:  ctrl = '{OP_NOP,       C_ALWAYS,   PC_IDLE};
      PC_EMIT_NO:  ctrl = '{OP_EMIT_FAIL, C_NONE,     PC_IDLE};
      PC_END_NO:   ctrl = '{OP_NOP,       C_ALWAYS,   PC_IDLE};
      PC_EMIT_ONE: ctrl = '{OP_EMIT_ZERO, C_NONE,     PC_IDLE};
      PC_END_ONE:  ctrl = '{OP_NOP,       C_ALWAYS,   PC_IDLE};
      default:     ctrl = '{OP_NOP,       C_ALWAYS,   PC_IDLE};
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = status.no_input;
      C_M_ZERO:   take = status.m_zero;
      C_M_ONE:    take = status.m_one;
      C_DIV_MORE: take = status.div_more;
      C_R1_ZERO:  take = status.r1_zero;
      C_GCD_NOT1: take = status.gcd_not1;
      default:    take = 1'b0;
    endcase
    // hold on an emit step while the result register is still occupied
    if ((ctrl.op == OP_EMIT_INV || ctrl.op == OP_EMIT_FAIL || ctrl.op == OP_EMIT_ZERO)
        && status.out_busy) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op   = ctrl.op;
  assign idle = (pc_r == PC_IDLE);

endmodule

FILE: rtl/mi_dp.sv
// Datapath: operand registers, shared shift-subtract divider and result register.
module mi_dp #(
  parameter int WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mi_pkg::op_t     op,
  input  logic            in_valid,
  input  mi_pkg::in_t     in_data,
  input  logic            out_ready,
  output logic            out_valid,
  output mi_pkg::out_t    out_data,
  output mi_pkg::status_t status
);
  import mi_pkg::*;

  localparam int MW    = WIDTH - 1;
  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [MW-1:0]    m_r, dvs_r, rem_r, acc_r, r0_r, r1_r, s0_r, s1_r;
  logic [WIDTH-1:0] val_r, dvd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r, pos_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;

  logic [WIDTH-1:0] trial, mag;
  logic [WIDTH:0]   diff;
  logic             qbit;
  logic [MW-1:0]    rem_step, acc_step, red_val, inv_val;
  logic [MW:0]      fold_diff;
  logic             out_busy, emit;

  // One quotient bit per cycle; the coefficient product q*s1 builds alongside
  assign trial    = {rem_r, dvd_r[WIDTH-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs_r};
  assign qbit     = ~diff[WIDTH];
  assign rem_step = qbit ? diff[MW-1:0] : trial[MW-1:0];
  assign acc_step = {acc_r[MW-2:0], 1'b0} + (qbit ? s1_r : '0);

  assign mag       = val_r[WIDTH-1] ? (WIDTH'(0) - val_r) : val_r;
  assign red_val   = (neg_r && rem_r != '0) ? (m_r - rem_r) : rem_r;
  assign fold_diff = {1'b0, s0_r} - {1'b0, m_r};
  assign inv_val   = (!pos_r && s0_r != '0) ? (m_r - s0_r) : s0_r;

  assign out_busy = out_valid_r && !out_ready;
  assign emit     = (op == OP_EMIT_INV || op == OP_EMIT_FAIL || op == OP_EMIT_ZERO)
                    && !out_busy;

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (in_valid) begin
          val_r <= in_data.value[WIDTH-1:0];
          m_r   <= in_data.modulus[MW-1:0];
        end
      end
      OP_RED_SET: begin
        neg_r <= val_r[WIDTH-1];
        dvd_r <= mag;
        dvs_r <= m_r;
        rem_r <= '0;
        acc_r <= '0;
        cnt_r <= CNT_W'(WIDTH);
      end
      OP_DIV_STEP: begin
        dvd_r <= {dvd_r[WIDTH-2:0], 1'b0};
        rem_r <= rem_step;
        acc_r <= acc_step;
        cnt_r <= cnt_r - 1'b1;
      end
      OP_RED_FIX: begin
        r0_r  <= m_r;
        r1_r  <= red_val;
        s0_r  <= '0;
        s1_r  <= MW'(1);
        pos_r <= 1'b0;
      end
      OP_EU_SET: begin
        dvd_r <= {1'b0, r0_r};
        dvs_r <= r1_r;
        rem_r <= '0;
        acc_r <= '0;
        cnt_r <= CNT_W'(WIDTH);
      end
      OP_EU_UPD: begin
        r0_r  <= r1_r;
        r1_r  <= rem_r;
        s0_r  <= s1_r;
        s1_r  <= s0_r + acc_r;
        pos_r <= ~pos_r;
      end
      OP_FOLD: begin
        if (!fold_diff[MW]) begin
          s0_r <= fold_diff[MW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      case (op)
        OP_EMIT_INV: out_data_r <= '{inverse: 63'(inv_val), no_inverse: 1'b0};
        OP_EMIT_FAIL: out_data_r <= '{inverse: '0, no_inverse: 1'b1};
        default: out_data_r <= '{inverse: '0, no_inverse: 1'b0};
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    status.no_input = !in_valid;
    status.m_zero   = (m_r == '0);
    status.m_one    = (m_r == MW'(1));
    status.div_more = (cnt_r != CNT_W'(1));
    status.r1_zero  = (r1_r == '0);
    status.gcd_not1 = (r0_r != MW'(1));
    status.out_busy = out_busy;
  end

endmodule
